/* sv/bmx_pkg.sv */
// Shared types and constants for the binary trie max-xor block.
// No dependencies; imported by bmx_engine and binary_trie_max_xor_top.
`timescale 1ns / 1ps

package bmx_pkg;

  localparam int KEY_BITS = 41;
  localparam int LVL_W    = $clog2(KEY_BITS);

  // request kinds
  localparam logic REQ_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [KEY_BITS-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] best_xor;
    logic [1:0]          status;
  } out_word_t;

endpackage

/* sv/binary_trie_max_xor_top.sv */
// Binary trie max-xor block: top level with node RAM, walk engine and output register.
// Depends on bmx_pkg, bmx_ram, bmx_engine.
// Flow: a query or insert walks the trie from the top key bit down, one node RAM access per level,
// then parks its result in the output register; an empty-set query or a refused insert ends early.
// One word at a time: the next word is taken only after the previous result leaves the engine.
// Reset: rst_n clears control, then a sweep zeroes every node RAM entry (in_stall high).
`timescale 1ns / 1ps

module binary_trie_max_xor_top #(
  parameter int NODE_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bmx_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bmx_pkg::out_word_t out_word
);
  import bmx_pkg::*;

  localparam int IDX_W   = $clog2(NODE_COUNT);
  localparam int ENTRY_W = 2 * (IDX_W + 1);

  logic               eng_ready;
  logic               eng_start;
  logic               res_valid;
  logic               res_take;
  out_word_t          res;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  assign in_stall  = !eng_ready;
  assign eng_start = in_valid && eng_ready;

  bmx_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bmx_engine #(
    .NODE_COUNT (NODE_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (eng_start),
    .req       (in_word),
    .ready     (eng_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register frees the engine as soon as the word is parked here
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* sv/bmx_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bmx_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/bmx_engine.sv */
// Trie walk engine: clear sweep, insert walk with node allocation, max-xor query walk.
// Depends on bmx_pkg; drives the node RAM ports (bmx_ram instance lives in the top).
`timescale 1ns / 1ps

module bmx_engine #(
  parameter int NODE_COUNT = 4096,
  localparam int IDX_W   = $clog2(NODE_COUNT),
  localparam int ENTRY_W = 2 * (IDX_W + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bmx_pkg::in_word_t   req,
  output logic                ready,
  output logic                res_valid,
  input  logic                res_take,
  output bmx_pkg::out_word_t  res,
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_waddr,
  output logic [ENTRY_W-1:0]  mem_wdata,
  output logic [IDX_W-1:0]    mem_raddr,
  input  logic [ENTRY_W-1:0]  mem_rdata
);
  import bmx_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_ALLOC = 5'b01000,
    S_FIN   = 5'b10000
  } fsm_t;

  localparam int SUM_W = IDX_W + 2;
  localparam logic [SUM_W-1:0] POOL_SIZE = SUM_W'(NODE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NODE_COUNT - 1);
  localparam logic [LVL_W-1:0] TOP_LVL   = LVL_W'(KEY_BITS - 1);

  fsm_t                state_r, state_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                query_r, query_nxt;
  logic [IDX_W-1:0]    node_r, node_nxt;
  logic [KEY_BITS-1:0] acc_r, acc_nxt;
  logic [IDX_W:0]      nf_r, nf_nxt;
  logic                has_keys_r, has_keys_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  out_word_t           res_r, res_nxt;

  logic             kbit;
  logic             v0, v1, hit_same, hit_opp;
  logic [IDX_W-1:0] i0, i1, idx_same, idx_opp, nf_idx, prev_idx;
  logic [IDX_W:0]   nf_dec;
  logic [SUM_W-1:0] pool_end;
  logic             full;
  logic [ENTRY_W-1:0] miss_data, alloc_data;

  // entry layout: {valid1, link1, valid0, link0}
  assign kbit     = key_r[lvl_r];
  assign v0       = mem_rdata[IDX_W];
  assign i0       = mem_rdata[IDX_W-1:0];
  assign v1       = mem_rdata[ENTRY_W-1];
  assign i1       = mem_rdata[ENTRY_W-2 -: IDX_W];
  assign hit_same = kbit ? v1 : v0;
  assign idx_same = kbit ? i1 : i0;
  assign hit_opp  = kbit ? v0 : v1;
  assign idx_opp  = kbit ? i0 : i1;

  assign nf_idx   = nf_r[IDX_W-1:0];
  assign nf_dec   = nf_r - 1'b1;
  assign prev_idx = nf_dec[IDX_W-1:0];

  // nodes needed from the first missing level down to bit 0
  assign pool_end = SUM_W'(nf_r) + SUM_W'(lvl_r) + SUM_W'(1);
  assign full     = pool_end > POOL_SIZE;

  assign miss_data  = kbit ? {1'b1, nf_idx, v0, i0} : {v1, i1, 1'b1, nf_idx};
  // freshly allocated nodes are known clear, so the other link stays empty
  assign alloc_data = kbit ? {1'b1, nf_idx, (IDX_W + 1)'(0)}
                           : {(IDX_W + 1)'(0), 1'b1, nf_idx};

  always_comb begin
    state_nxt    = state_r;
    lvl_nxt      = lvl_r;
    key_nxt      = key_r;
    query_nxt    = query_r;
    node_nxt     = node_r;
    acc_nxt      = acc_r;
    nf_nxt       = nf_r;
    has_keys_nxt = has_keys_r;
    clr_nxt      = clr_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        // root read is always in flight so the walk starts the cycle after accept
        mem_raddr = '0;
        if (start) begin
          key_nxt   = req.key;
          query_nxt = (req.req_type == REQ_QUERY);
          lvl_nxt   = TOP_LVL;
          node_nxt  = '0;
          acc_nxt   = '0;
          if (req.req_type == REQ_QUERY && !has_keys_r) begin
            res_nxt   = '{best_xor: '0, status: STAT_EMPTY};
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (query_r) begin
          if (hit_opp || hit_same) begin
            if (hit_opp) begin
              acc_nxt[lvl_r] = 1'b1;
            end
            if (lvl_r == '0) begin
              res_nxt   = '{best_xor: acc_nxt, status: STAT_OK};
              state_nxt = S_FIN;
            end else begin
              node_nxt  = hit_opp ? idx_opp : idx_same;
              mem_raddr = node_nxt;
              lvl_nxt   = lvl_r - 1'b1;
            end
          end else begin
            res_nxt   = '{best_xor: acc_r, status: STAT_OK};
            state_nxt = S_FIN;
          end
        end else if (hit_same) begin
          if (lvl_r == '0) begin
            // duplicate key: nothing to allocate
            has_keys_nxt = 1'b1;
            res_nxt      = '{best_xor: '0, status: STAT_OK};
            state_nxt    = S_FIN;
          end else begin
            node_nxt  = idx_same;
            mem_raddr = idx_same;
            lvl_nxt   = lvl_r - 1'b1;
          end
        end else if (full) begin
          res_nxt   = '{best_xor: '0, status: STAT_FULL};
          state_nxt = S_FIN;
        end else begin
          // hook the new path onto the last existing node, keep its other link
          mem_we    = 1'b1;
          mem_waddr = node_r;
          mem_wdata = miss_data;
          nf_nxt    = nf_r + 1'b1;
          if (lvl_r == '0) begin
            has_keys_nxt = 1'b1;
            res_nxt      = '{best_xor: '0, status: STAT_OK};
            state_nxt    = S_FIN;
          end else begin
            lvl_nxt   = lvl_r - 1'b1;
            state_nxt = S_ALLOC;
          end
        end
      end

      S_ALLOC: begin
        mem_we    = 1'b1;
        mem_waddr = prev_idx;
        mem_wdata = alloc_data;
        nf_nxt    = nf_r + 1'b1;
        if (lvl_r == '0) begin
          has_keys_nxt = 1'b1;
          res_nxt      = '{best_xor: '0, status: STAT_OK};
          state_nxt    = S_FIN;
        end else begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end

      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      nf_r       <= (IDX_W + 1)'(1);
      has_keys_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      nf_r       <= nf_nxt;
      has_keys_r <= has_keys_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    key_r   <= key_nxt;
    query_r <= query_nxt;
    node_r  <= node_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
  end

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res       = res_r;

  // pool pointer never runs past the end of the pool
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(nf_r) <= POOL_SIZE)
    else $error("free-node pointer beyond pool");

  // node store is only written by the clear sweep or by an insert
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_ALLOC ||
                (state_r == S_WALK && !query_r)))
    else $error("node write outside clear or insert");

  // allocation steps down one level per cycle until bit 0
  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC && lvl_r != '0) |=>
      (state_r == S_ALLOC && lvl_r == $past(lvl_r) - 1'b1))
    else $error("allocation level sequence broken");

  // a waiting result is held until it is taken
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !res_take) |=> (state_r == S_FIN && $stable(res_r)))
    else $error("pending result changed");

endmodule

/* verif/bmx_checker.sv */
// Checker for the binary trie max-xor block: watches both channels, keeps its own trie
// predictor and compares every result word with the oldest expected one.
// Depends on bmx_pkg.
`timescale 1ns / 1ps

module bmx_checker #(
  parameter int POOL_NODES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bmx_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bmx_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);

  localparam int KB        = bmx_pkg::KEY_BITS;
  localparam int COUNT_SAT = 8191;
  localparam int PRINT_MAX = 50;

  // predictor state: child links and their valid bits per pool node
  int unsigned child_idx [POOL_NODES][2];
  bit          child_ok  [POOL_NODES][2];
  int unsigned free_node;
  int unsigned stored_cnt;

  bmx_pkg::out_word_t expected_words[$];
  int fails = 0;
  int waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  function automatic bit has_kid(input int unsigned n, input bit b);
    return n < POOL_NODES && child_ok[n][b] && child_idx[n][b] < POOL_NODES;
  endfunction

  function automatic logic [1:0] trie_insert(input logic [KB-1:0] k);
    int unsigned n;
    int unsigned need;
    bit          b;
    bit          off_path;
    int          i;
    n = 0;
    need = 0;
    off_path = 1'b0;
    // count the nodes this key would add before touching anything
    for (i = KB - 1; i >= 0; i--) begin
      b = k[i];
      if (!off_path && has_kid(n, b)) begin
        n = child_idx[n][b];
      end else begin
        off_path = 1'b1;
        need++;
      end
    end
    if (free_node + need > POOL_NODES) return bmx_pkg::STAT_FULL;
    n = 0;
    for (i = KB - 1; i >= 0; i--) begin
      b = k[i];
      if (!has_kid(n, b)) begin
        child_idx[n][b] = free_node;
        child_ok[n][b]  = 1'b1;
        free_node++;
      end
      n = child_idx[n][b];
    end
    if (stored_cnt < COUNT_SAT) stored_cnt++;
    return bmx_pkg::STAT_OK;
  endfunction

  function automatic logic [KB-1:0] trie_best_xor(input logic [KB-1:0] k);
    int unsigned   n;
    logic [KB-1:0] acc;
    bit            b;
    int            i;
    n = 0;
    acc = '0;
    for (i = KB - 1; i >= 0; i--) begin
      b = k[i];
      if (has_kid(n, !b)) begin
        acc[i] = 1'b1;
        n = child_idx[n][!b];
      end else if (has_kid(n, b)) begin
        n = child_idx[n][b];
      end else begin
        break;
      end
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fails++;
    if (fails <= PRINT_MAX)
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    bmx_pkg::out_word_t want;
    if (!rst_n) begin
      for (int n = 0; n < POOL_NODES; n++) begin
        child_ok[n][0]  = 1'b0;
        child_ok[n][1]  = 1'b0;
        child_idx[n][0] = 0;
        child_idx[n][1] = 0;
      end
      free_node  = 1;
      stored_cnt = 0;
      expected_words.delete();
      waiting = 0;
    end else begin
      if (in_valid && !in_stall) begin
        want.best_xor = '0;
        if (in_word.req_type == bmx_pkg::REQ_QUERY) begin
          if (stored_cnt == 0) begin
            want.status = bmx_pkg::STAT_EMPTY;
          end else begin
            want.best_xor = trie_best_xor(in_word.key);
            want.status   = bmx_pkg::STAT_OK;
          end
        end else begin
          want.status = trie_insert(in_word.key);
        end
        expected_words.push_back(want);
        waiting++;
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_word), 64'd0);
        end else begin
          want = expected_words.pop_front();
          waiting--;
          if (out_word.best_xor !== want.best_xor)
            report_mismatch("best_xor", 64'(out_word.best_xor), 64'(want.best_xor));
          if (out_word.status !== want.status)
            report_mismatch("status", 64'(out_word.status), 64'(want.status));
        end
      end
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the binary trie max-xor testbench: clock, reset, request stimulus with random
// gaps, random result stalls, and the final verdict.
// Depends on bmx_pkg, binary_trie_max_xor_top and bmx_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int KB         = bmx_pkg::KEY_BITS;
  localparam int POOL_NODES = 4096;
  localparam int RAND_WORDS = 835;
  localparam logic REQ_INSERT = ~bmx_pkg::REQ_QUERY;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  bmx_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  bmx_pkg::out_word_t out_word;
  int                 fail_count;
  int                 pending;

  logic [KB-1:0] sent_keys[$];
  logic [KB-1:0] family[8];
  bit            steady;

  binary_trie_max_xor_top #(.NODE_COUNT(POOL_NODES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  bmx_checker #(.POOL_NODES(POOL_NODES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [KB-1:0] rand_key();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    return wide[KB-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with valid still high
  task automatic send_word(input logic kind, input logic [KB-1:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_word.req_type = kind;
    in_word.key      = k;
    if (kind == REQ_INSERT) sent_keys.push_back(k);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stall bursts, occasionally a long clear stretch
  initial begin
    int r;
    int n;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) n = 0;
      else if (r < 85) n = $urandom_range(1, 4);
      else if (r < 97) n = $urandom_range(5, 20);
      else n = $urandom_range(30, 60);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if ($urandom_range(0, 19) == 0) repeat (300) @(negedge clk);
    end
  end

  initial begin
    logic [KB-1:0] ones;
    logic [KB-1:0] alt;
    logic [KB-1:0] k;
    logic [KB-1:0] low_mask;
    int            r;
    int            w;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    steady   = 1'b0;
    ones     = '1;
    alt      = KB'({(KB + 1) / 2{2'b01}});
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty set, extremes, duplicates, single-bit keys
    send_word(bmx_pkg::REQ_QUERY, '0);
    send_word(bmx_pkg::REQ_QUERY, ones);
    send_word(REQ_INSERT, '0);
    send_word(bmx_pkg::REQ_QUERY, '0);
    send_word(bmx_pkg::REQ_QUERY, ones);
    send_word(REQ_INSERT, ones);
    send_word(bmx_pkg::REQ_QUERY, '0);
    send_word(bmx_pkg::REQ_QUERY, alt);
    send_word(REQ_INSERT, '0);
    send_word(REQ_INSERT, ones);
    send_word(REQ_INSERT, KB'(1) << (KB - 1));
    send_word(bmx_pkg::REQ_QUERY, KB'(1) << (KB - 1));
    send_word(REQ_INSERT, KB'(1));
    send_word(bmx_pkg::REQ_QUERY, KB'(1));
    send_word(REQ_INSERT, alt);
    send_word(REQ_INSERT, ~alt);
    send_word(bmx_pkg::REQ_QUERY, alt);
    send_word(bmx_pkg::REQ_QUERY, ~alt);
    send_word(REQ_INSERT, KB'(1) << 20);
    send_word(bmx_pkg::REQ_QUERY, rand_key());

    for (int f = 0; f < 8; f++) family[f] = rand_key();

    // random: families sharing long prefixes, fresh keys that drain the pool,
    // duplicates, and queries near stored keys
    for (w = 0; w < RAND_WORDS; w++) begin
      if (w % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      if (w == RAND_WORDS / 2) begin
        // let everything drain before carrying on
        in_valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          low_mask = (KB'(1) << $urandom_range(1, 12)) - KB'(1);
          k = family[$urandom_range(0, 7)] ^ (rand_key() & low_mask);
        end else if (r < 88 || sent_keys.size() == 0) begin
          k = rand_key();
        end else begin
          k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        end
        send_word(REQ_INSERT, k);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50 || sent_keys.size() == 0) begin
          k = rand_key();
        end else if (r < 80) begin
          low_mask = (KB'(1) << $urandom_range(1, 16)) - KB'(1);
          k = sent_keys[$urandom_range(0, sent_keys.size() - 1)] ^ (rand_key() & low_mask);
        end else begin
          k = ~sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        end
        send_word(bmx_pkg::REQ_QUERY, k);
      end
    end

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bmx_pkg.sv
sv/bmx_ram.sv
sv/bmx_engine.sv
sv/binary_trie_max_xor_top.sv
verif/bmx_checker.sv
verif/testbench.sv
